// File: src/cmg_pkg.sv
// ----------------------------------------------------------------------------
// cmg_pkg
// Shared types, constants and calendar tables for the month grid block.
// ----------------------------------------------------------------------------
package cmg_pkg;

   // Field widths of the request and response words.
   localparam int OP_W    = 2;
   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int WHICH_W = 2;
   localparam int LEAD_W  = 3;
   localparam int TRAIL_W = 4;

   // Default number of cells in the six-week grid.
   localparam int GRID_CELLS_DEF = 42;

   // Request operation codes.
   localparam logic [OP_W-1:0] OP_SET  = 2'd0;
   localparam logic [OP_W-1:0] OP_PREV = 2'd1;
   localparam logic [OP_W-1:0] OP_NEXT = 2'd2;

   // Which month a cell belongs to.
   localparam logic [WHICH_W-1:0] WHICH_PREV = 2'd0;
   localparam logic [WHICH_W-1:0] WHICH_CUR  = 2'd1;
   localparam logic [WHICH_W-1:0] WHICH_NEXT = 2'd2;

   // Year and month limits and reset values.
   localparam logic [YEAR_W-1:0]  YEAR_MIN        = 14'd1;
   localparam logic [YEAR_W-1:0]  YEAR_MAX        = 14'd9999;
   localparam logic [YEAR_W-1:0]  YEAR_RESET      = 14'd2000;
   localparam logic [MONTH_W-1:0] MONTH_FIRST     = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB       = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_MAR       = 4'd3;
   localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = 4'd12;

   // Division by 100 through a reciprocal: exact for values up to 9999.
   localparam int               DIV100_MULT_W = 13;
   localparam logic [12:0]      DIV100_MULT   = 13'd5243;
   localparam int               DIV100_SHIFT  = 19;
   localparam int               Q100_W        = 7;
   localparam int               PROD_W        = YEAR_W + DIV100_MULT_W;

   // Width of the weekday sum before reduction modulo seven.
   localparam int               SUM_W         = 15;
   localparam logic [3:0]       DAYS_PER_WEEK = 4'd7;

   // Month parameters handed from the date pipeline to the cell generator.
   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [LEAD_W-1:0]  lead;
      logic [TRAIL_W-1:0] trail;
      logic [DAY_W-1:0]   dim;
      logic [DAY_W-1:0]   prev_dim;
   } grid_info_type;

   // Number of days in a month, given whether the year is a leap year.
   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] d;
      d = 5'd31;
      if (m == MONTH_FEB) begin
         d = leap ? 5'd29 : 5'd28;
      end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
         d = 5'd30;
      end
      return d;
   endfunction

   // Month offset of the weekday formula.
   function automatic logic [2:0] dow_offset(input logic [MONTH_W-1:0] m);
      logic [2:0] r;
      case (m)
         4'd1:    r = 3'd0;
         4'd2:    r = 3'd3;
         4'd3:    r = 3'd2;
         4'd4:    r = 3'd5;
         4'd5:    r = 3'd0;
         4'd6:    r = 3'd3;
         4'd7:    r = 3'd5;
         4'd8:    r = 3'd1;
         4'd9:    r = 3'd4;
         4'd10:   r = 3'd6;
         4'd11:   r = 3'd2;
         4'd12:   r = 3'd4;
         default: r = 3'd0;
      endcase
      return r;
   endfunction

endpackage

// File: src/calendar_month_grid.sv
// ----------------------------------------------------------------------------
// calendar_month_grid
// Monday-first six-week month grid on the proleptic Gregorian calendar.
// ----------------------------------------------------------------------------
// Each request word sets the shown year and month, or steps one month back or
// forward (saturating at January of year 1 and December of year 9999), or
// keeps them (unused operation code), and yields GRID_CELLS response words,
// one per grid cell in row-major order. The cell generator sends one word per
// cycle while rsp_ready stays high; that single output port sets the
// throughput. The first cell of a request leaves through the state register,
// a three-stage date pipeline and the cell generator's registers. Up to four
// further requests are taken while a grid is still being sent.
module calendar_month_grid #(
   parameter int GRID_CELLS = cmg_pkg::GRID_CELLS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [cmg_pkg::OP_W-1:0]      req_op,
   input  logic [cmg_pkg::YEAR_W-1:0]    req_new_year,
   input  logic [cmg_pkg::MONTH_W-1:0]   req_new_month,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [$clog2(GRID_CELLS)-1:0] rsp_cell_index,
   output logic [cmg_pkg::DAY_W-1:0]     rsp_day_number,
   output logic [cmg_pkg::WHICH_W-1:0]   rsp_which_month,
   output logic [cmg_pkg::YEAR_W-1:0]    rsp_shown_year,
   output logic [cmg_pkg::MONTH_W-1:0]   rsp_shown_month,
   output logic [cmg_pkg::LEAD_W-1:0]    rsp_lead_cells,
   output logic [cmg_pkg::TRAIL_W-1:0]   rsp_trail_cells,
   output logic                          rsp_last_cell
);
   import cmg_pkg::*;

   logic               st_v_ff;
   logic [YEAR_W-1:0]  year_held_ff, year_held_in;
   logic [MONTH_W-1:0] month_held_ff, month_held_in;
   logic               st_load;
   logic               mi_ready, mi_valid, cg_ready;
   grid_info_type      mi_info;

   // The held state doubles as the word handed to the date pipeline.
   assign req_ready = !st_v_ff || mi_ready;
   assign st_load   = req_valid && req_ready;

   // Next shown year and month.
   always_comb begin
      year_held_in  = year_held_ff;
      month_held_in = month_held_ff;
      case (req_op)
         OP_SET: begin
            if (req_new_year < YEAR_MIN) begin
               year_held_in = YEAR_MIN;
            end else if (req_new_year > YEAR_MAX) begin
               year_held_in = YEAR_MAX;
            end else begin
               year_held_in = req_new_year;
            end
            if (req_new_month < MONTH_FIRST) begin
               month_held_in = MONTH_FIRST;
            end else if (req_new_month > MONTHS_PER_YEAR) begin
               month_held_in = MONTHS_PER_YEAR;
            end else begin
               month_held_in = req_new_month;
            end
         end
         OP_PREV: begin
            if (month_held_ff > MONTH_FIRST) begin
               month_held_in = month_held_ff - 4'd1;
            end else if (year_held_ff > YEAR_MIN) begin
               year_held_in  = year_held_ff - 14'd1;
               month_held_in = MONTHS_PER_YEAR;
            end
         end
         OP_NEXT: begin
            if (month_held_ff < MONTHS_PER_YEAR) begin
               month_held_in = month_held_ff + 4'd1;
            end else if (year_held_ff < YEAR_MAX) begin
               year_held_in  = year_held_ff + 14'd1;
               month_held_in = MONTH_FIRST;
            end
         end
         default: begin
            year_held_in  = year_held_ff;
            month_held_in = month_held_ff;
         end
      endcase
   end

   // Shown year and month, and whether a word waits for the date pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_v_ff       <= 1'b0;
         year_held_ff  <= YEAR_RESET;
         month_held_ff <= MONTH_FIRST;
      end else begin
         if (st_load) begin
            st_v_ff       <= 1'b1;
            year_held_ff  <= year_held_in;
            month_held_ff <= month_held_in;
         end else if (mi_ready) begin
            st_v_ff <= 1'b0;
         end
      end
   end

   // Grid layout of the shown month.
   cmg_month_info #(
      .GRID_CELLS (GRID_CELLS)
   ) u_month_info (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (st_v_ff),
      .in_ready  (mi_ready),
      .in_year   (year_held_ff),
      .in_month  (month_held_ff),
      .out_valid (mi_valid),
      .out_ready (cg_ready),
      .out_info  (mi_info)
   );

   // One response word per grid cell.
   cmg_cell_gen #(
      .GRID_CELLS (GRID_CELLS)
   ) u_cell_gen (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (mi_valid),
      .in_ready        (cg_ready),
      .in_info         (mi_info),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_cell_index  (rsp_cell_index),
      .rsp_day_number  (rsp_day_number),
      .rsp_which_month (rsp_which_month),
      .rsp_shown_year  (rsp_shown_year),
      .rsp_shown_month (rsp_shown_month),
      .rsp_lead_cells  (rsp_lead_cells),
      .rsp_trail_cells (rsp_trail_cells),
      .rsp_last_cell   (rsp_last_cell)
   );

endmodule

// File: src/cmg_month_info.sv
// ----------------------------------------------------------------------------
// cmg_month_info
// Three-stage pipeline that turns a year and month into the grid layout:
// weekday of the first day, leading and trailing cell counts, month lengths.
// ----------------------------------------------------------------------------
module cmg_month_info #(
   parameter int GRID_CELLS = cmg_pkg::GRID_CELLS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [cmg_pkg::YEAR_W-1:0]   in_year,
   input  logic [cmg_pkg::MONTH_W-1:0]  in_month,
   output logic                         out_valid,
   input  logic                         out_ready,
   output cmg_pkg::grid_info_type       out_info
);
   import cmg_pkg::*;

   localparam int CW = $clog2(GRID_CELLS);

   // Stage valids and handshake between stages.
   logic b_v_ff, c_v_ff, d_v_ff;
   logic b_load, c_load, d_load;
   logic b_free, c_free, d_free;

   assign d_free   = !d_v_ff || out_ready;
   assign d_load   = c_v_ff && d_free;
   assign c_free   = !c_v_ff || d_load;
   assign c_load   = b_v_ff && c_free;
   assign b_free   = !b_v_ff || c_load;
   assign b_load   = in_valid && b_free;
   assign in_ready = b_free;
   assign out_valid = d_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
      end else begin
         if (b_load) begin
            b_v_ff <= 1'b1;
         end else if (c_load) begin
            b_v_ff <= 1'b0;
         end
         if (c_load) begin
            c_v_ff <= 1'b1;
         end else if (d_load) begin
            c_v_ff <= 1'b0;
         end
         if (d_load) begin
            d_v_ff <= 1'b1;
         end else if (out_ready) begin
            d_v_ff <= 1'b0;
         end
      end
   end

   // Stage b: the weekday year (January and February count with the year
   // before) and both years divided by 100 through reciprocal multiplies.
   logic [YEAR_W-1:0]  yy_in;
   logic [PROD_W-1:0]  prod_yy, prod_y;
   logic [YEAR_W-1:0]  b_year_ff, b_yy_ff;
   logic [MONTH_W-1:0] b_month_ff;
   logic [Q100_W-1:0]  b_q100yy_ff, b_q100y_ff;

   assign yy_in   = (in_month < MONTH_MAR) ? in_year - YEAR_MIN : in_year;
   assign prod_yy = PROD_W'(yy_in) * PROD_W'(DIV100_MULT);
   assign prod_y  = PROD_W'(in_year) * PROD_W'(DIV100_MULT);

   always_ff @(posedge clock) begin
      if (b_load) begin
         b_year_ff   <= in_year;
         b_month_ff  <= in_month;
         b_yy_ff     <= yy_in;
         b_q100yy_ff <= prod_yy[DIV100_SHIFT+Q100_W-1:DIV100_SHIFT];
         b_q100y_ff  <= prod_y[DIV100_SHIFT+Q100_W-1:DIV100_SHIFT];
      end
   end

   // Stage c: the weekday sum and the leap year test.
   logic [SUM_W-1:0]   sum_in;
   logic [YEAR_W-1:0]  y100;
   logic               leap_in;
   logic [SUM_W-1:0]   c_sum_ff;
   logic               c_leap_ff;
   logic [YEAR_W-1:0]  c_year_ff;
   logic [MONTH_W-1:0] c_month_ff;

   assign sum_in = SUM_W'(b_yy_ff) + SUM_W'(b_yy_ff >> 2) - SUM_W'(b_q100yy_ff)
                 + SUM_W'(b_q100yy_ff >> 2) + SUM_W'(dow_offset(b_month_ff))
                 + SUM_W'(1);
   assign y100    = YEAR_W'(b_q100y_ff) * YEAR_W'(100);
   assign leap_in = (b_year_ff[1:0] == 2'd0)
                 && ((b_year_ff != y100) || (b_q100y_ff[1:0] == 2'd0));

   always_ff @(posedge clock) begin
      if (c_load) begin
         c_sum_ff   <= sum_in;
         c_leap_ff  <= leap_in;
         c_year_ff  <= b_year_ff;
         c_month_ff <= b_month_ff;
      end
   end

   // Stage d: reduce the sum modulo seven by folding octal digits, since
   // eight is one more than seven, then derive the grid layout.
   logic [5:0]         fold1;
   logic [3:0]         fold2;
   logic [2:0]         dow;
   logic [LEAD_W-1:0]  lead_in;
   logic [DAY_W-1:0]   dim_in, prev_dim_in;
   logic [CW-1:0]      trail_full;
   grid_info_type      info_ff;

   assign fold1 = 6'(c_sum_ff[2:0]) + 6'(c_sum_ff[5:3]) + 6'(c_sum_ff[8:6])
                + 6'(c_sum_ff[11:9]) + 6'(c_sum_ff[14:12]);
   assign fold2 = 4'(fold1[2:0]) + 4'(fold1[5:3]);
   assign dow   = (fold2 >= DAYS_PER_WEEK) ? 3'(fold2 - DAYS_PER_WEEK) : 3'(fold2);

   // Sunday leads six cells, Monday a full week, other days one fewer.
   always_comb begin
      if (dow == 3'd0) begin
         lead_in = 3'd6;
      end else if (dow == 3'd1) begin
         lead_in = 3'd7;
      end else begin
         lead_in = dow - 3'd1;
      end
   end

   assign dim_in      = month_len(c_month_ff, c_leap_ff);
   assign prev_dim_in = (c_month_ff == MONTH_FIRST) ? 5'd31
                      : month_len(c_month_ff - MONTH_FIRST, c_leap_ff);
   assign trail_full  = CW'(GRID_CELLS) - CW'(lead_in) - CW'(dim_in);

   always_ff @(posedge clock) begin
      if (d_load) begin
         info_ff.year     <= c_year_ff;
         info_ff.month    <= c_month_ff;
         info_ff.lead     <= lead_in;
         info_ff.trail    <= TRAIL_W'(trail_full);
         info_ff.dim      <= dim_in;
         info_ff.prev_dim <= prev_dim_in;
      end
   end

   assign out_info = info_ff;

endmodule

// File: src/cmg_cell_gen.sv
// ----------------------------------------------------------------------------
// cmg_cell_gen
// Walks the grid one cell per cycle when not stalled; registers the response.
// ----------------------------------------------------------------------------
module cmg_cell_gen #(
   parameter int GRID_CELLS = cmg_pkg::GRID_CELLS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  cmg_pkg::grid_info_type        in_info,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [$clog2(GRID_CELLS)-1:0] rsp_cell_index,
   output logic [cmg_pkg::DAY_W-1:0]     rsp_day_number,
   output logic [cmg_pkg::WHICH_W-1:0]   rsp_which_month,
   output logic [cmg_pkg::YEAR_W-1:0]    rsp_shown_year,
   output logic [cmg_pkg::MONTH_W-1:0]   rsp_shown_month,
   output logic [cmg_pkg::LEAD_W-1:0]    rsp_lead_cells,
   output logic [cmg_pkg::TRAIL_W-1:0]   rsp_trail_cells,
   output logic                          rsp_last_cell
);
   import cmg_pkg::*;

   localparam int CW = $clog2(GRID_CELLS);
   localparam logic [CW-1:0] CELL_LAST = CW'(GRID_CELLS - 1);

   logic               gen_v_ff;
   logic [CW-1:0]      cell_ff;
   logic [DAY_W-1:0]   day_ff;
   logic [WHICH_W-1:0] which_ff;
   grid_info_type      info_ff;
   logic               rsp_v_ff;

   logic               out_load, is_last, gen_free, gen_load;

   assign out_load = gen_v_ff && (!rsp_v_ff || rsp_ready);
   assign is_last  = (cell_ff == CELL_LAST);
   assign gen_free = !gen_v_ff || (out_load && is_last);
   assign gen_load = in_valid && gen_free;
   assign in_ready = gen_free;

   // Generator control: busy from loading a month until its last cell leaves.
   always_ff @(posedge clock) begin
      if (reset) begin
         gen_v_ff <= 1'b0;
      end else if (gen_load) begin
         gen_v_ff <= 1'b1;
      end else if (out_load && is_last) begin
         gen_v_ff <= 1'b0;
      end
   end

   // Cell stepper: previous-month days run up to their month end, then the
   // shown month from one, then the next month from one.
   always_ff @(posedge clock) begin
      if (gen_load) begin
         info_ff  <= in_info;
         cell_ff  <= '0;
         day_ff   <= in_info.prev_dim - DAY_W'(in_info.lead) + 5'd1;
         which_ff <= WHICH_PREV;
      end else if (out_load) begin
         cell_ff <= cell_ff + CW'(1);
         if ((which_ff == WHICH_PREV) && (day_ff == info_ff.prev_dim)) begin
            day_ff   <= 5'd1;
            which_ff <= WHICH_CUR;
         end else if ((which_ff == WHICH_CUR) && (day_ff == info_ff.dim)) begin
            day_ff   <= 5'd1;
            which_ff <= WHICH_NEXT;
         end else begin
            day_ff <= day_ff + 5'd1;
         end
      end
   end

   // Response register valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (out_load) begin
         rsp_v_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_v_ff <= 1'b0;
      end
   end

   // Response register payload.
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_cell_index  <= cell_ff;
         rsp_day_number  <= day_ff;
         rsp_which_month <= which_ff;
         rsp_shown_year  <= info_ff.year;
         rsp_shown_month <= info_ff.month;
         rsp_lead_cells  <= info_ff.lead;
         rsp_trail_cells <= info_ff.trail;
         rsp_last_cell   <= is_last;
      end
   end

   assign rsp_valid = rsp_v_ff;

endmodule

// File: verif/calendar_month_grid_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// calendar_month_grid_tb
// Self-checking testbench for the Monday-first six-week month grid.
// ----------------------------------------------------------------------------
// Request words set the shown month or step it back and forward. A model of
// the block counts days from January 1 of year 1, which was a Monday, and
// queues the 42 cell words that each request should produce. Every cell word
// that the block sends is compared field by field with the oldest queued one.
// Directed tests cover the field extremes, clamping, saturation at both ends
// of the calendar, year wrap and the unused operation. A random phase follows,
// with random idle cycles on both channels and a stretch without them.
// ----------------------------------------------------------------------------
module calendar_month_grid_tb;

   import cmg_pkg::*;

   localparam int NUM_CELLS    = GRID_CELLS_DEF;
   localparam int RANDOM_WORDS = 480;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_WAIT  = 20;

   // The block ignores the fourth operation code and repeats the held month.
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   // One expected cell word.
   typedef struct {
      logic [5:0]         cell_index;
      logic [DAY_W-1:0]   day_number;
      logic [WHICH_W-1:0] which_month;
      logic [YEAR_W-1:0]  shown_year;
      logic [MONTH_W-1:0] shown_month;
      logic [LEAD_W-1:0]  lead_cells;
      logic [TRAIL_W-1:0] trail_cells;
      logic               last_cell;
   } grid_cell_type;

   logic                clock         = 1'b0;
   logic                reset         = 1'b1;
   logic                req_valid     = 1'b0;
   logic                req_ready;
   logic [OP_W-1:0]     req_op        = OP_SET;
   logic [YEAR_W-1:0]   req_new_year  = '0;
   logic [MONTH_W-1:0]  req_new_month = '0;
   logic                rsp_valid;
   logic                rsp_ready     = 1'b0;
   logic [5:0]          rsp_cell_index;
   logic [DAY_W-1:0]    rsp_day_number;
   logic [WHICH_W-1:0]  rsp_which_month;
   logic [YEAR_W-1:0]   rsp_shown_year;
   logic [MONTH_W-1:0]  rsp_shown_month;
   logic [LEAD_W-1:0]   rsp_lead_cells;
   logic [TRAIL_W-1:0]  rsp_trail_cells;
   logic                rsp_last_cell;

   // Model copy of the shown month and the cells still owed by the block.
   int unsigned         model_year  = YEAR_RESET;
   int unsigned         model_month = MONTH_FIRST;
   grid_cell_type       pending_cells[$];

   int unsigned         fail_count    = 0;
   int unsigned         cells_checked = 0;
   int unsigned         words_sent    = 0;
   int unsigned         cycle_count   = 0;
   bit                  sender_idles   = 1'b1;
   bit                  receiver_idles = 1'b1;

   calendar_month_grid #(
      .GRID_CELLS (NUM_CELLS)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_new_year    (req_new_year),
      .req_new_month   (req_new_month),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_cell_index  (rsp_cell_index),
      .rsp_day_number  (rsp_day_number),
      .rsp_which_month (rsp_which_month),
      .rsp_shown_year  (rsp_shown_year),
      .rsp_shown_month (rsp_shown_month),
      .rsp_lead_cells  (rsp_lead_cells),
      .rsp_trail_cells (rsp_trail_cells),
      .rsp_last_cell   (rsp_last_cell)
   );

   always #10 clock = ~clock;

   // Days in a month of the proleptic Gregorian calendar.
   function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
      bit leap;
      leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
      case (m)
         2:             return leap ? 29 : 28;
         4, 6, 9, 11:   return 30;
         default:       return 31;
      endcase
   endfunction

   // Apply one request to the model month and queue the grid it produces.
   function automatic void predict_month_grid(input logic [OP_W-1:0] op,
                                              input logic [YEAR_W-1:0] new_year,
                                              input logic [MONTH_W-1:0] new_month);
      int unsigned   y;
      int unsigned   m;
      int unsigned   days;
      int unsigned   lead;
      int unsigned   dim;
      int unsigned   prev_dim;
      grid_cell_type entry;
      if (op == OP_SET) begin
         y = new_year;
         m = new_month;
         if (y < YEAR_MIN) y = YEAR_MIN;
         if (y > YEAR_MAX) y = YEAR_MAX;
         if (m < MONTH_FIRST) m = MONTH_FIRST;
         if (m > MONTHS_PER_YEAR) m = MONTHS_PER_YEAR;
         model_year  = y;
         model_month = m;
      end else if (op == OP_PREV) begin
         if (model_month > MONTH_FIRST) begin
            model_month--;
         end else if (model_year > YEAR_MIN) begin
            model_year--;
            model_month = MONTHS_PER_YEAR;
         end
      end else if (op == OP_NEXT) begin
         if (model_month < MONTHS_PER_YEAR) begin
            model_month++;
         end else if (model_year < YEAR_MAX) begin
            model_year++;
            model_month = MONTH_FIRST;
         end
      end
      y = model_year;
      m = model_month;

      // Days from Monday, January 1 of year 1, to the first of the month
      // give the weekday directly; a Monday start gets a full leading week.
      days = 365 * (y - 1) + (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400;
      for (int k = 1; k < m; k++) begin
         days += month_days(y, k);
      end
      lead = days % 7;
      if (lead == 0) lead = 7;
      dim      = month_days(y, m);
      prev_dim = (m == 1) ? 31 : month_days(y, m - 1);

      for (int i = 0; i < NUM_CELLS; i++) begin
         entry.cell_index  = 6'(i);
         entry.shown_year  = YEAR_W'(y);
         entry.shown_month = MONTH_W'(m);
         entry.lead_cells  = LEAD_W'(lead);
         entry.trail_cells = TRAIL_W'(NUM_CELLS - lead - dim);
         entry.last_cell   = (i == NUM_CELLS - 1);
         if (i < lead) begin
            entry.day_number  = DAY_W'(prev_dim - lead + i + 1);
            entry.which_month = WHICH_PREV;
         end else if (i < lead + dim) begin
            entry.day_number  = DAY_W'(i - lead + 1);
            entry.which_month = WHICH_CUR;
         end else begin
            entry.day_number  = DAY_W'(i - lead - dim + 1);
            entry.which_month = WHICH_NEXT;
         end
         pending_cells.push_back(entry);
      end
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // Receiver side ready, with random stalls while idling is enabled.
   always @(posedge clock) begin
      rsp_ready <= receiver_idles ? ($urandom_range(0, 99) >= 10) : 1'b1;
   end

   // Compare each accepted cell word with the oldest expected one.
   always @(posedge clock) begin : cell_checker
      grid_cell_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_cells.size() == 0) begin
            $error("cell word %0d arrived with none expected", rsp_cell_index);
            fail_count++;
         end else begin
            want = pending_cells.pop_front();
            cells_checked++;
            check_field("cell_index", want.cell_index, rsp_cell_index);
            check_field("day_number", want.day_number, rsp_day_number);
            check_field("which_month", want.which_month, rsp_which_month);
            check_field("shown_year", want.shown_year, rsp_shown_year);
            check_field("shown_month", want.shown_month, rsp_shown_month);
            check_field("lead_cells", want.lead_cells, rsp_lead_cells);
            check_field("trail_cells", want.trail_cells, rsp_trail_cells);
            check_field("last_cell", want.last_cell, rsp_last_cell);
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL calendar_month_grid");
         $finish;
      end
   end

   // Send one request word and queue its expected grid once accepted.
   task automatic send_word(input logic [OP_W-1:0] op, input logic [YEAR_W-1:0] y,
                            input logic [MONTH_W-1:0] m);
      while (sender_idles && $urandom_range(0, 99) < 10) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_op        <= op;
      req_new_year  <= y;
      req_new_month <= m;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_month_grid(op, y, m);
      words_sent++;
   endtask

   // Hold off the sender until every expected cell has arrived.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_cells.size() != 0) @(posedge clock);
   endtask

   // Right after reset the block should still show January 2000.
   task automatic test_reset_month();
      send_word(OP_UNUSED, YEAR_W'($urandom), MONTH_W'($urandom));
   endtask

   // Field extremes, clamping, leap rules and a month starting on Monday.
   task automatic test_set_extremes();
      send_word(OP_SET, 14'd0, 4'd0);
      send_word(OP_SET, 14'd1, 4'd1);
      send_word(OP_SET, 14'd9999, 4'd12);
      send_word(OP_SET, 14'd16383, 4'd15);
      send_word(OP_SET, 14'd10000, 4'd13);
      send_word(OP_SET, 14'd2000, 4'd2);
      send_word(OP_SET, 14'd1900, 4'd2);
      send_word(OP_SET, 14'd2024, 4'd2);
      send_word(OP_SET, 14'd2024, 4'd1);
      send_word(OP_SET, 14'd2023, 4'd5);
      send_word(OP_SET, 14'd8191, 4'd7);
      send_word(OP_SET, 14'd5461, 4'd10);
   endtask

   // Saturation at both ends of the calendar and wrap across years.
   task automatic test_step_limits();
      send_word(OP_SET, 14'd1, 4'd1);
      send_word(OP_PREV, 14'd16383, 4'd15);
      send_word(OP_NEXT, 14'd0, 4'd0);
      send_word(OP_SET, 14'd9999, 4'd12);
      send_word(OP_NEXT, 14'd0, 4'd0);
      send_word(OP_PREV, 14'd16383, 4'd15);
      send_word(OP_SET, 14'd1999, 4'd12);
      send_word(OP_NEXT, 14'd0, 4'd0);
      send_word(OP_PREV, 14'd0, 4'd0);
   endtask

   // The unused operation keeps the held month even with full-scale fields.
   task automatic test_unused_op();
      send_word(OP_UNUSED, 14'd16383, 4'd15);
   endtask

   // Random requests: mostly valid dates and steps, some out-of-range noise.
   task automatic test_random_words();
      int unsigned    pick;
      logic [OP_W-1:0] op;
      logic [YEAR_W-1:0] y;
      logic [MONTH_W-1:0] m;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         // A middle stretch runs both channels at full rate.
         sender_idles   = !(n >= 160 && n < 320);
         receiver_idles = sender_idles;
         if (n % 100 == 99) wait_for_drain();
         pick = $urandom_range(0, 99);
         op = (pick < 40) ? OP_SET : (pick < 65) ? OP_PREV :
              (pick < 95) ? OP_NEXT : OP_UNUSED;
         pick = $urandom_range(0, 99);
         if (pick < 70)      y = YEAR_W'($urandom_range(1, 9999));
         else if (pick < 80) y = YEAR_W'($urandom_range(1, 3));
         else if (pick < 90) y = YEAR_W'($urandom_range(9997, 9999));
         else                y = YEAR_W'($urandom);
         m = ($urandom_range(0, 9) == 0) ? MONTH_W'($urandom)
                                         : MONTH_W'($urandom_range(1, 12));
         send_word(op, y, m);
      end
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_reset_month();
      test_set_extremes();
      test_step_limits();
      test_unused_op();
      wait_for_drain();
      test_random_words();

      // Let the last grid drain, then watch for stray words.
      wait_for_drain();
      repeat (SETTLE_WAIT) @(posedge clock);

      $display("Sent %0d request words and checked %0d grid cells,", words_sent,
               cells_checked);
      $display("covering set, step, clamp, saturation and unused-op words.");
      if (fail_count == 0 && pending_cells.size() == 0) begin
         $display("PASS calendar_month_grid");
      end else begin
         $display("FAIL calendar_month_grid");
      end
      $finish;
   end

endmodule

// File: files.f
src/cmg_pkg.sv
src/cmg_month_info.sv
src/cmg_cell_gen.sv
src/calendar_month_grid.sv
verif/calendar_month_grid_tb.sv
